FILE: sv/pan_tilt_servo_slew_controller_defines.svh
// Assertion macros shared by the pan/tilt servo controller RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef PAN_TILT_SERVO_SLEW_CONTROLLER_DEFINES_SVH
`define PAN_TILT_SERVO_SLEW_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PTSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ptsc_pkg.sv
// Types and constants for the pan/tilt servo slew controller.
// No dependencies.
package ptsc_pkg;

  // Command codes on the input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_HOME  = 2'd1;
  localparam logic [1:0] CMD_CELL  = 2'd2;
  localparam logic [1:0] CMD_POINT = 2'd3;

  // Aim mode reported on the result word
  localparam logic [1:0] AIM_IDLE  = 2'd0;
  localparam logic [1:0] AIM_GRID  = 2'd1;
  localparam logic [1:0] AIM_TRACK = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_PAN_MIN     = 3'd0;
  localparam logic [2:0] CFG_PAN_MAX     = 3'd1;
  localparam logic [2:0] CFG_TILT_MIN    = 3'd2;
  localparam logic [2:0] CFG_TILT_MAX    = 3'd3;
  localparam logic [2:0] CFG_PAN_INVERT  = 3'd4;
  localparam logic [2:0] CFG_TILT_INVERT = 3'd5;
  localparam logic [2:0] CFG_STEP_SIZE   = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int US_W       = 12;
  localparam int DEG_W      = 8;
  localparam int TRACK_W    = 17;

  localparam logic [DEG_W-1:0]  DEG_FULL  = 8'd180;
  localparam logic [DEG_W-1:0]  DEG_HOME  = 8'd90;
  localparam logic [TRACK_W-1:0] TRACK_ONE = 17'd65536;

  // n/180 as (n * RECIP_180) >> RECIP_SHIFT, exact for n < 2^20
  localparam int NUM_W       = 20;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_180 = 21'd1491309;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         grid_cell;
    logic [TRACK_W-1:0] track_x;
    logic [TRACK_W-1:0] track_y;
  } ptsc_in_t;

  typedef struct packed {
    logic [US_W-1:0]  pan_pulse_us;
    logic [US_W-1:0]  tilt_pulse_us;
    logic [DEG_W-1:0] pan_angle_deg;
    logic [DEG_W-1:0] tilt_angle_deg;
    logic [1:0]       mode_now;
  } ptsc_out_t;

  // Stage loads handed to the pulse converters
  typedef struct packed {
    logic ld_mid;
    logic ld_out;
  } ptsc_adv_t;

  // Grid column -> pan degrees, cells 1..9 row-major
  function automatic logic [DEG_W-1:0] col_pan_deg(input logic [3:0] num);
    logic [DEG_W-1:0] d;
    case (num)
      4'd1, 4'd4, 4'd7: d = 8'd30;
      4'd3, 4'd6, 4'd9: d = 8'd150;
      default:          d = 8'd90;
    endcase
    return d;
  endfunction

  // Grid row -> tilt degrees
  function automatic logic [DEG_W-1:0] row_tilt_deg(input logic [3:0] num);
    logic [DEG_W-1:0] d;
    case (num)
      4'd1, 4'd2, 4'd3: d = 8'd120;
      4'd7, 4'd8, 4'd9: d = 8'd60;
      default:          d = 8'd90;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/pan_tilt_servo_slew_controller.sv
// Pan/tilt servo aim controller with slew limiting, top level.
// Depends on ptsc_pkg, ptsc_pulse and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | input     | in_valid/in_ready  | in_data   (ptsc_in_t)
//  out     | output    | out_valid/out_ready| out_data  (ptsc_out_t)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle in and out while out_ready does not stall the output; a result word
// is valid once its accepted input word has passed stage A (angle update and rounding),
// stage B (span multiply) and the output register (reciprocal divide by 180).
// Each stage loads when empty or when its successor frees up; in_ready drops
// only when all three stages hold words and out_ready is low.
// Synchronous active-high reset returns to 90/90 idle and default config.
module pan_tilt_servo_slew_controller
  import ptsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptsc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptsc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "pan_tilt_servo_slew_controller_defines.svh"

  localparam int AW       = DEG_W + ANGLE_FRAC_BITS;
  localparam int SW       = (AW > CFG_DATA_W) ? AW : CFG_DATA_W;
  localparam int TR_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam int TR_W     = TRACK_W + DEG_W;
  localparam logic [AW-1:0]   HOME_ANG  = AW'(DEG_HOME) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0]   FULL_ANG  = AW'(DEG_FULL) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0]   RND_HALF  = AW'(1) << (ANGLE_FRAC_BITS - 1);
  localparam logic [TR_W-1:0] TR_HALF   = TR_W'(1) << (TR_SHIFT - 1);
  localparam logic [CFG_DATA_W-1:0] STEP_RESET = CFG_DATA_W'(3 << ANGLE_FRAC_BITS);

  // Configuration registers
  logic [US_W-1:0]       pan_min_us, pan_max_us, tilt_min_us, tilt_max_us;
  logic                  pan_invert, tilt_invert;
  logic [CFG_DATA_W-1:0] step_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_min_us  <= US_W'(1000);
      pan_max_us  <= US_W'(2000);
      tilt_min_us <= US_W'(1000);
      tilt_max_us <= US_W'(2000);
      pan_invert  <= 1'b1;
      tilt_invert <= 1'b1;
      step_size   <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAN_MIN:     pan_min_us  <= cfg_data[US_W-1:0];
        CFG_PAN_MAX:     pan_max_us  <= cfg_data[US_W-1:0];
        CFG_TILT_MIN:    tilt_min_us <= cfg_data[US_W-1:0];
        CFG_TILT_MAX:    tilt_max_us <= cfg_data[US_W-1:0];
        CFG_PAN_INVERT:  pan_invert  <= cfg_data[0];
        CFG_TILT_INVERT: tilt_invert <= cfg_data[0];
        CFG_STEP_SIZE:   step_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline stage occupancy and loads
  logic a_v, b_v;
  logic a_free, b_free, out_free, in_acc;
  ptsc_adv_t adv;

  always_comb begin
    out_free   = !out_valid || out_ready;
    b_free     = !b_v || out_free;
    a_free     = !a_v || b_free;
    in_ready   = a_free;
    in_acc     = in_valid && a_free;
    adv.ld_mid = b_free;
    adv.ld_out = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free)   a_v       <= in_acc;
      if (b_free)   b_v       <= a_v;
      if (out_free) out_valid <= b_v;
    end
  end

  // Move cur toward tgt by at most step, landing exactly on tgt
  function automatic logic [AW-1:0] slew(input logic [AW-1:0] cur,
                                         input logic [AW-1:0] tgt,
                                         input logic [SW-1:0] step);
    logic [AW-1:0] r;
    if (cur < tgt) begin
      r = (SW'(tgt - cur) > step) ? (cur + AW'(step)) : tgt;
    end else if (cur > tgt) begin
      r = (SW'(cur - tgt) > step) ? (cur - AW'(step)) : tgt;
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // Round half up to whole degrees, capped at 180
  function automatic logic [DEG_W-1:0] round_deg(input logic [AW-1:0] a);
    logic [AW-1:0]    s;
    logic [DEG_W-1:0] d;
    s = a + RND_HALF;
    d = s[AW-1:ANGLE_FRAC_BITS];
    return (d > DEG_FULL) ? DEG_FULL : d;
  endfunction

  // Track coordinate -> target angle, 180*c/65536 rounded half up, c capped at 65536
  function automatic logic [AW-1:0] track_tgt(input logic [TRACK_W-1:0] c);
    logic [TRACK_W-1:0] v;
    logic [TR_W-1:0]    p;
    v = (c > TRACK_ONE) ? TRACK_ONE : c;
    p = TR_W'(v) * TR_W'(DEG_FULL) + TR_HALF;
    return AW'(p >> TR_SHIFT);
  endfunction

  // Aim state
  logic [AW-1:0] pan_angle, pan_target, tilt_angle, tilt_target;
  logic [1:0]    aim_mode;
  logic [AW-1:0] pan_angle_next, pan_target_next, tilt_angle_next, tilt_target_next;
  logic [1:0]    aim_mode_next;

  always_comb begin
    pan_angle_next   = pan_angle;
    tilt_angle_next  = tilt_angle;
    pan_target_next  = pan_target;
    tilt_target_next = tilt_target;
    aim_mode_next    = aim_mode;
    case (in_data.mode)
      CMD_TICK: begin
        pan_angle_next  = slew(pan_angle, pan_target, SW'(step_size));
        tilt_angle_next = slew(tilt_angle, tilt_target, SW'(step_size));
      end
      CMD_HOME: begin
        aim_mode_next    = AIM_IDLE;
        pan_target_next  = HOME_ANG;
        tilt_target_next = HOME_ANG;
      end
      CMD_CELL: begin
        if (in_data.grid_cell inside {[4'd1:4'd9]}) begin
          aim_mode_next    = AIM_GRID;
          pan_target_next  = AW'(col_pan_deg(in_data.grid_cell)) << ANGLE_FRAC_BITS;
          tilt_target_next = AW'(row_tilt_deg(in_data.grid_cell)) << ANGLE_FRAC_BITS;
        end
      end
      CMD_POINT: begin
        aim_mode_next    = AIM_TRACK;
        pan_target_next  = track_tgt(in_data.track_x);
        tilt_target_next = track_tgt(in_data.track_y);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_angle   <= HOME_ANG;
      pan_target  <= HOME_ANG;
      tilt_angle  <= HOME_ANG;
      tilt_target <= HOME_ANG;
      aim_mode    <= AIM_IDLE;
    end else if (in_acc) begin
      pan_angle   <= pan_angle_next;
      pan_target  <= pan_target_next;
      tilt_angle  <= tilt_angle_next;
      tilt_target <= tilt_target_next;
      aim_mode    <= aim_mode_next;
    end
  end

  // Stage A: rounded degrees of the updated angles
  logic [DEG_W-1:0] a_pan_deg, a_tilt_deg, b_pan_deg, b_tilt_deg;
  logic [1:0]       a_mode, b_mode;

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_pan_deg  <= round_deg(pan_angle_next);
      a_tilt_deg <= round_deg(tilt_angle_next);
      a_mode     <= aim_mode_next;
    end
  end

  // Stage B: carry degrees alongside the pulse multiply
  always_ff @(posedge clk) begin
    if (b_free) begin
      b_pan_deg  <= a_pan_deg;
      b_tilt_deg <= a_tilt_deg;
      b_mode     <= a_mode;
    end
  end

  // Pulse converters, one per axis
  logic [US_W-1:0] pan_pulse, tilt_pulse;

  ptsc_pulse u_pan_pulse (
    .clk    (clk),
    .adv    (adv),
    .deg    (a_pan_deg),
    .invert (pan_invert),
    .lo     (pan_min_us),
    .hi     (pan_max_us),
    .pulse  (pan_pulse)
  );

  ptsc_pulse u_tilt_pulse (
    .clk    (clk),
    .adv    (adv),
    .deg    (a_tilt_deg),
    .invert (tilt_invert),
    .lo     (tilt_min_us),
    .hi     (tilt_max_us),
    .pulse  (tilt_pulse)
  );

  // Output register, pulses come registered from the converters
  logic [DEG_W-1:0] o_pan_deg, o_tilt_deg;
  logic [1:0]       o_mode;

  always_ff @(posedge clk) begin
    if (out_free) begin
      o_pan_deg  <= b_pan_deg;
      o_tilt_deg <= b_tilt_deg;
      o_mode     <= b_mode;
    end
  end

  always_comb begin
    out_data.pan_pulse_us   = pan_pulse;
    out_data.tilt_pulse_us  = tilt_pulse;
    out_data.pan_angle_deg  = o_pan_deg;
    out_data.tilt_angle_deg = o_tilt_deg;
    out_data.mode_now       = o_mode;
  end

  // Checks
  `PTSC_ASSERT_NOW(a_angle_range, 1'b1, (pan_angle <= FULL_ANG) && (tilt_angle <= FULL_ANG), "angle beyond 180 degrees")
  `PTSC_ASSERT_NOW(a_aim_code, 1'b1, aim_mode != 2'd3, "aim mode holds unused code")
  `PTSC_ASSERT_NEXT(a_zero_step, in_acc && (in_data.mode == CMD_TICK) && (step_size == '0), (pan_angle == $past(pan_angle)) && (tilt_angle == $past(tilt_angle)), "zero step moved an angle")
  `PTSC_ASSERT_NOW(a_full_pipe, in_acc && a_v && b_v && out_valid, out_ready, "accepted into a stalled full pipeline")

endmodule

FILE: sv/ptsc_pulse.sv
// Degree to servo pulse width conversion, two register stages.
// Depends on ptsc_pkg.
module ptsc_pulse
  import ptsc_pkg::*;
(
  input  logic             clk,
  input  ptsc_adv_t        adv,
  input  logic [DEG_W-1:0] deg,
  input  logic             invert,
  input  logic [US_W-1:0]  lo,
  input  logic [US_W-1:0]  hi,
  output logic [US_W-1:0]  pulse
);

  logic [DEG_W-1:0] deg_c;
  logic [US_W-1:0]  span;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] mid_num;
  logic [US_W-1:0]  mid_lo;
  logic             mid_flat;
  logic [NUM_W+RECIP_W-1:0] quot_prod;
  logic [US_W-1:0]  quot;

  // span*d + 90, later divided by 180 for half-up rounding
  always_comb begin
    deg_c = invert ? (DEG_FULL - deg) : deg;
    span  = hi - lo;
    num   = NUM_W'(span) * NUM_W'(deg_c) + NUM_W'(DEG_HOME);
  end

  always_ff @(posedge clk) begin
    if (adv.ld_mid) begin
      mid_num  <= num;
      mid_lo   <= lo;
      mid_flat <= (hi < lo);
    end
  end

  // Divide by 180 through the reciprocal
  always_comb begin
    quot_prod = (NUM_W+RECIP_W)'(mid_num) * (NUM_W+RECIP_W)'(RECIP_180);
    quot      = quot_prod[RECIP_SHIFT +: US_W];
  end

  always_ff @(posedge clk) begin
    if (adv.ld_out) begin
      pulse <= mid_flat ? mid_lo : (mid_lo + quot);
    end
  end

endmodule
